[hdl/mmc_pkg.sv]
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared widths, codes and transaction types of the magnetometer calibrator.
// ----------------------------------------------------------------------------
package mmc_pkg;

  // field widths
  localparam int RAW_W   = 12;  // ADC reading
  localparam int AVG_W   = 13;  // averaged reading, Z includes bias
  localparam int SPAN_W  = AVG_W + 1;
  localparam int SCALE_W = 14;
  localparam int OUT_W   = 16;
  localparam int ZB_W    = 12;
  localparam int CL_W    = 10;
  localparam int PH_W    = 2;

  // request codes on the input channel
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_BUTTON = 1'b1;

  // event kinds in the front-to-back queue
  localparam logic EV_SAMPLE = 1'b0;
  localparam logic EV_BUTTON = 1'b1;

  // calibration phases
  localparam logic [PH_W-1:0] PH_NORMAL = 2'd0;
  localparam logic [PH_W-1:0] PH_XY     = 2'd1;
  localparam logic [PH_W-1:0] PH_Z      = 2'd2;

  // reset values
  localparam logic [AVG_W-1:0] MIN_RESET        = 13'd3300;
  localparam logic [ZB_W-1:0]  Z_BIAS_RESET     = 12'd1500;
  localparam logic [CL_W-1:0]  CAL_LENGTH_RESET = 10'd800;

  // event queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic             kind;
    logic [RAW_W-1:0] avg_x;
    logic [RAW_W-1:0] avg_y;
    logic [AVG_W-1:0] avg_z;
  } evt_t;

  typedef struct packed {
    logic                     start;
    logic signed [SPAN_W-1:0] num;
    logic signed [SPAN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [SCALE_W-1:0] quo;
  } div_rsp_t;

endpackage

[hdl/magnetometer_minmax_calibration.sv]
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration
// Three-axis magnetometer hard-iron calibrator using the min/max method.
// ----------------------------------------------------------------------------
// A sample transaction carries one row of X/Y/Z ADC readings; every AVG_ROWS
// rows the block averages each axis (truncating), adds z_bias to Z and sends
// one result: per axis scale * (average - midpoint), saturated to 16 bits
// signed, with the phase in force. Button transactions never give a result;
// they step the phase from normal to X/Y tracking to Z tracking and back,
// and the press that ends Z tracking computes midpoints and integer scales
// (X and Y scale = Z span / own span, Z scale 1, zero divisor gives 0).
// Until the first calibration completes all scales are zero, so results are
// zero. Extremes accumulate across calibrations until reset.
// Rate: the input takes one transaction per cycle. The row that completes its
// average reaches out_valid through the front stages, the event queue and the
// product and output registers. The press that ends Z tracking holds the back
// end while one shared serial divider produces the X scale and then the Y
// scale, one quotient bit per cycle; the four-entry event queue and the two
// front stages keep taking input, and only when they are full does in_stall
// rise. Registers: z_bias at byte address 0, cal_length at byte address 4.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibration #(
  parameter int AVG_ROWS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_req_type,
  input  logic [mmc_pkg::RAW_W-1:0]         in_raw_x,
  input  logic [mmc_pkg::RAW_W-1:0]         in_raw_y,
  input  logic [mmc_pkg::RAW_W-1:0]         in_raw_z,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [mmc_pkg::OUT_W-1:0]  out_x,
  output logic signed [mmc_pkg::OUT_W-1:0]  out_y,
  output logic signed [mmc_pkg::OUT_W-1:0]  out_z,
  output logic [mmc_pkg::PH_W-1:0]          out_cal_phase,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import mmc_pkg::*;

  // register index, taken from byte address bit 2
  localparam logic REG_Z_BIAS     = 1'b0;
  localparam logic REG_CAL_LENGTH = 1'b1;

  logic [ZB_W-1:0] z_bias_r;
  logic [CL_W-1:0] cal_length_r;
  logic            cfg_wr;
  logic            cfg_sel;

  logic            q_push;
  evt_t            q_push_evt;
  logic            q_full;
  logic            q_pop;
  evt_t            q_head;
  logic            q_empty;

  // --------------------------------------------------------------------------
  // Configuration registers; the port never waits
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      z_bias_r     <= Z_BIAS_RESET;
      cal_length_r <= CAL_LENGTH_RESET;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_Z_BIAS:     z_bias_r     <= pwdata[ZB_W-1:0];
        REG_CAL_LENGTH: cal_length_r <= pwdata[CL_W-1:0];
        default:        z_bias_r     <= z_bias_r;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_Z_BIAS:     prdata = 32'(z_bias_r);
      REG_CAL_LENGTH: prdata = 32'(cal_length_r);
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front end: accept, accumulate rows, divide by the row count
  // --------------------------------------------------------------------------
  mmc_front #(
    .AVG_ROWS (AVG_ROWS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_raw_x    (in_raw_x),
    .in_raw_y    (in_raw_y),
    .in_raw_z    (in_raw_z),
    .z_bias      (z_bias_r),
    .q_push      (q_push),
    .q_push_evt  (q_push_evt),
    .q_full      (q_full)
  );

  // --------------------------------------------------------------------------
  // Event queue: lets the front keep going while the back end divides
  // --------------------------------------------------------------------------
  mmc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_evt (q_push_evt),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // --------------------------------------------------------------------------
  // Back end: tracking, correction and end-of-calibration arithmetic
  // --------------------------------------------------------------------------
  mmc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cal_length    (cal_length_r),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_cal_phase (out_cal_phase)
  );

endmodule

[hdl/mmc_front.sv]
// ----------------------------------------------------------------------------
// mmc_front
// Accept input transactions, sum ADC rows and turn each full block of rows
// into an averaged event; button presses pass through as events.
// ----------------------------------------------------------------------------
module mmc_front #(
  parameter int AVG_ROWS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_req_type,
  input  logic [mmc_pkg::RAW_W-1:0]  in_raw_x,
  input  logic [mmc_pkg::RAW_W-1:0]  in_raw_y,
  input  logic [mmc_pkg::RAW_W-1:0]  in_raw_z,
  input  logic [mmc_pkg::ZB_W-1:0]   z_bias,
  output logic                       q_push,
  output mmc_pkg::evt_t              q_push_evt,
  input  logic                       q_full
);
  import mmc_pkg::*;

  localparam int SUM_W  = $clog2(AVG_ROWS * 4095 + 1);
  localparam int SH     = SUM_W;
  localparam int RCP_W  = SH + 1;
  localparam int PRD_W  = SUM_W + RCP_W;
  localparam int CNT_W  = (AVG_ROWS > 1) ? $clog2(AVG_ROWS) : 1;
  localparam longint RECIP_L = (longint'(1) << SH) / AVG_ROWS;
  localparam logic [RCP_W-1:0] RECIP    = RCP_W'(RECIP_L);
  localparam logic [CNT_W-1:0] LAST_ROW = CNT_W'(AVG_ROWS - 1);
  localparam logic [SUM_W:0]   DIVISOR  = (SUM_W + 1)'(AVG_ROWS);

  logic [SUM_W-1:0] acc_r    [3];
  logic [CNT_W-1:0] row_r;
  logic             s1_v_r;
  logic             s1_kind_r;
  logic [SUM_W-1:0] s1_sum_r [3];
  logic             s2_v_r;
  logic             s2_kind_r;
  logic [SUM_W-1:0] s2_sum_r [3];
  logic [PRD_W-1:0] s2_prd_r [3];

  logic [RAW_W-1:0] raw      [3];
  logic [SUM_W-1:0] row_sum  [3];
  logic [RCP_W-1:0] q_est    [3];
  logic [RAW_W-1:0] q_lo     [3];
  logic [SUM_W:0]   q_mul    [3];
  logic [SUM_W:0]   q_rem    [3];
  logic [RAW_W-1:0] quo      [3];
  logic             adv;
  logic             take;
  logic             is_btn;
  logic             last;

  assign raw[0] = in_raw_x;
  assign raw[1] = in_raw_y;
  assign raw[2] = in_raw_z;

  assign adv      = !(s2_v_r && q_full);
  assign in_stall = !adv;
  assign take     = in_valid && adv;
  assign is_btn   = (in_req_type == REQ_BUTTON);
  assign last     = (row_r == LAST_ROW);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      row_sum[k] = acc_r[k] + SUM_W'(raw[k]);
      // reciprocal estimate is floor or floor minus one: fix with one compare
      q_est[k]   = s2_prd_r[k][PRD_W-1:SH];
      q_lo[k]    = q_est[k][RAW_W-1:0];
      q_mul[k]   = (SUM_W + 1)'(q_lo[k]) * DIVISOR;
      q_rem[k]   = {1'b0, s2_sum_r[k]} - q_mul[k];
      quo[k]     = (q_rem[k] >= DIVISOR) ? q_lo[k] + 1'b1 : q_lo[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      for (int k = 0; k < 3; k++) acc_r[k] <= '0;
    end else if (adv) begin
      s2_v_r <= s1_v_r;
      s1_v_r <= take && (is_btn || last);
      if (take && !is_btn) begin
        if (last) begin
          row_r <= '0;
          for (int k = 0; k < 3; k++) acc_r[k] <= '0;
        end else begin
          row_r <= row_r + 1'b1;
          for (int k = 0; k < 3; k++) acc_r[k] <= row_sum[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= is_btn ? EV_BUTTON : EV_SAMPLE;
      s2_kind_r <= s1_kind_r;
      for (int k = 0; k < 3; k++) begin
        s1_sum_r[k] <= row_sum[k];
        s2_sum_r[k] <= s1_sum_r[k];
        s2_prd_r[k] <= PRD_W'(s1_sum_r[k]) * PRD_W'(RECIP);
      end
    end
  end

  assign q_push           = s2_v_r && !q_full;
  assign q_push_evt.kind  = s2_kind_r;
  assign q_push_evt.avg_x = quo[0];
  assign q_push_evt.avg_y = quo[1];
  assign q_push_evt.avg_z = AVG_W'(quo[2]) + AVG_W'(z_bias);

endmodule

[hdl/mmc_fifo.sv]
// ----------------------------------------------------------------------------
// mmc_fifo
// Short event queue between the front and the back end.
// ----------------------------------------------------------------------------
module mmc_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  mmc_pkg::evt_t push_evt,
  output logic          full,
  input  logic          pop,
  output mmc_pkg::evt_t head,
  output logic          empty
);
  import mmc_pkg::*;

  evt_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r;
  logic [Q_AW-1:0] rd_r;
  logic [Q_AW:0]   cnt_r;

  assign full  = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_evt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[hdl/mmc_div.sv]
// ----------------------------------------------------------------------------
// mmc_div
// Signed radix-2 restoring divider, one quotient bit per cycle, truncating
// toward zero; a zero divisor returns zero.
// ----------------------------------------------------------------------------
module mmc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mmc_pkg::div_req_t req,
  output mmc_pkg::div_rsp_t rsp
);
  import mmc_pkg::*;

  localparam int CNT_W = $clog2(SPAN_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SPAN_W-1:0] quo_r;
  logic [SPAN_W:0]   rem_r;
  logic [SPAN_W-1:0] den_r;
  logic              neg_r;
  logic              zero_r;

  logic [SPAN_W:0]   rem_sh;
  logic              fits;
  logic [SPAN_W-1:0] num_mag;
  logic [SPAN_W-1:0] den_mag;

  assign num_mag = req.num[SPAN_W-1] ? SPAN_W'(-req.num) : SPAN_W'(req.num);
  assign den_mag = req.den[SPAN_W-1] ? SPAN_W'(-req.den) : SPAN_W'(req.den);
  assign rem_sh  = {rem_r[SPAN_W-1:0], quo_r[SPAN_W-1]};
  assign fits    = (rem_sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(SPAN_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      quo_r  <= num_mag;
      rem_r  <= '0;
      den_r  <= den_mag;
      neg_r  <= req.num[SPAN_W-1] ^ req.den[SPAN_W-1];
      zero_r <= (req.den == '0);
    end else if (busy_r) begin
      rem_r <= fits ? rem_sh - {1'b0, den_r} : rem_sh;
      quo_r <= {quo_r[SPAN_W-2:0], fits};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = zero_r ? '0 : (neg_r ? SCALE_W'(-quo_r) : SCALE_W'(quo_r));

endmodule

[hdl/mmc_back.sv]
// ----------------------------------------------------------------------------
// mmc_back
// Carry out queued events: track extremes, apply scale and midpoint, and
// run the end-of-calibration midpoint and scale computation.
// ----------------------------------------------------------------------------
module mmc_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [mmc_pkg::CL_W-1:0]       cal_length,
  input  logic                           q_empty,
  input  mmc_pkg::evt_t                  q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [mmc_pkg::OUT_W-1:0] out_x,
  output logic signed [mmc_pkg::OUT_W-1:0] out_y,
  output logic signed [mmc_pkg::OUT_W-1:0] out_z,
  output logic [mmc_pkg::PH_W-1:0]       out_cal_phase
);
  import mmc_pkg::*;

  localparam int DIFF_W = AVG_W + 2;
  localparam int PROD_W = SCALE_W + DIFF_W;

  localparam logic [1:0] B_RUN  = 2'd0;
  localparam logic [1:0] B_DIVX = 2'd1;
  localparam logic [1:0] B_DIVY = 2'd2;

  localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-32768);

  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > SAT_HI)      r = 16'sh7FFF;
    else if (v < SAT_LO) r = 16'sh8000;
    else                 r = v[OUT_W-1:0];
    return r;
  endfunction

  logic [PH_W-1:0]            phase_r;
  logic [CL_W-1:0]            tracked_r;
  logic [1:0]                 bst_r;
  logic [AVG_W-1:0]           max_r    [3];
  logic [AVG_W-1:0]           min_r    [3];
  logic [AVG_W-1:0]           mid_r    [3];
  logic signed [SCALE_W-1:0]  scale_r  [3];
  logic                       m_v_r;
  logic [PH_W-1:0]            m_ph_r;
  logic signed [PROD_W-1:0]   m_prod_r [3];
  logic                       o_v_r;
  logic [PH_W-1:0]            o_ph_r;
  logic signed [OUT_W-1:0]    o_val_r  [3];

  logic [AVG_W-1:0]           avg      [3];
  logic signed [DIFF_W-1:0]   diff     [3];
  logic signed [PROD_W-1:0]   prod     [3];
  logic signed [SPAN_W-1:0]   span     [3];
  logic [AVG_W:0]             ext_sum  [3];
  logic [AVG_W-1:0]           mid_calc [3];
  logic                       trk_en   [3];
  logic                       out_adv;
  logic                       m_adv;
  logic                       is_btn;
  logic                       pop_avg;
  logic                       pop_btn;
  logic                       track;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;

  assign avg[0] = AVG_W'(q_head.avg_x);
  assign avg[1] = AVG_W'(q_head.avg_y);
  assign avg[2] = q_head.avg_z;

  assign out_adv = !o_v_r || !out_stall;
  assign m_adv   = !m_v_r || out_adv;
  assign is_btn  = (q_head.kind == EV_BUTTON);
  assign q_pop   = !q_empty && (bst_r == B_RUN) && (is_btn || m_adv);
  assign pop_avg = q_pop && !is_btn;
  assign pop_btn = q_pop && is_btn;
  assign track   = pop_avg && ((phase_r == PH_XY) || (phase_r == PH_Z)) &&
                   (tracked_r < cal_length);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k]     = $signed({2'b00, avg[k]}) - $signed({2'b00, mid_r[k]});
      prod[k]     = PROD_W'(scale_r[k]) * PROD_W'(diff[k]);
      span[k]     = $signed({1'b0, max_r[k]}) - $signed({1'b0, min_r[k]});
      ext_sum[k]  = {1'b0, max_r[k]} + {1'b0, min_r[k]};
      mid_calc[k] = ext_sum[k][AVG_W:1];
      trk_en[k]   = (phase_r == PH_XY) ? (k < 2) : (k == 2);
    end
  end

  // Z span over X span, then over Y span
  assign div_req.start = (pop_btn && (phase_r != PH_NORMAL) && (phase_r != PH_XY)) ||
                         ((bst_r == B_DIVX) && div_rsp.done);
  assign div_req.num   = span[2];
  assign div_req.den   = (bst_r == B_DIVX) ? span[1] : span[0];

  mmc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_NORMAL;
      tracked_r <= '0;
      bst_r     <= B_RUN;
      m_v_r     <= 1'b0;
      o_v_r     <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        max_r[k]   <= '0;
        min_r[k]   <= MIN_RESET;
        mid_r[k]   <= '0;
        scale_r[k] <= '0;
      end
    end else begin
      if (out_adv) o_v_r <= m_v_r;
      if (m_adv)   m_v_r <= pop_avg;
      if (track) begin
        tracked_r <= tracked_r + 1'b1;
        for (int k = 0; k < 3; k++) begin
          if (trk_en[k]) begin
            if (avg[k] > max_r[k]) max_r[k] <= avg[k];
            if (avg[k] < min_r[k]) min_r[k] <= avg[k];
          end
        end
      end
      if (pop_btn) begin
        tracked_r <= '0;
        case (phase_r)
          PH_NORMAL: phase_r <= PH_XY;
          PH_XY:     phase_r <= PH_Z;
          default: begin
            phase_r <= PH_NORMAL;
            bst_r   <= B_DIVX;
            for (int k = 0; k < 3; k++) mid_r[k] <= mid_calc[k];
          end
        endcase
      end
      if ((bst_r == B_DIVX) && div_rsp.done) begin
        scale_r[0] <= div_rsp.quo;
        bst_r      <= B_DIVY;
      end
      if ((bst_r == B_DIVY) && div_rsp.done) begin
        scale_r[1] <= div_rsp.quo;
        scale_r[2] <= SCALE_W'(1);
        bst_r      <= B_RUN;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_avg) begin
      m_ph_r <= phase_r;
      for (int k = 0; k < 3; k++) m_prod_r[k] <= prod[k];
    end
    if (out_adv && m_v_r) begin
      o_ph_r <= m_ph_r;
      for (int k = 0; k < 3; k++) o_val_r[k] <= sat16(m_prod_r[k]);
    end
  end

  assign out_valid     = o_v_r;
  assign out_x         = o_val_r[0];
  assign out_y         = o_val_r[1];
  assign out_z         = o_val_r[2];
  assign out_cal_phase = o_ph_r;

endmodule

[verif/magnetometer_minmax_calibration_checker.sv]
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration_checker
// Predicts the calibrator's corrected readings and compares them at the port.
// ----------------------------------------------------------------------------
// Watches the input, result and register channels of the calibrator. Every
// accepted input transaction advances a private copy of the calibration state;
// each completed average queues one expected reading. Every accepted result is
// checked field by field against the oldest queued reading.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibration_checker #(
  parameter int         AVG_ROWS = 10,
  parameter logic [2:0] ZB_ADDR  = 3'd0,
  parameter logic [2:0] CL_ADDR  = 3'd4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              in_req_type,
  input  logic [mmc_pkg::RAW_W-1:0]         in_raw_x,
  input  logic [mmc_pkg::RAW_W-1:0]         in_raw_y,
  input  logic [mmc_pkg::RAW_W-1:0]         in_raw_z,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [mmc_pkg::OUT_W-1:0]  out_x,
  input  logic signed [mmc_pkg::OUT_W-1:0]  out_y,
  input  logic signed [mmc_pkg::OUT_W-1:0]  out_z,
  input  logic [mmc_pkg::PH_W-1:0]          out_cal_phase,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  input  logic                              pready,
  output int                                mismatch_count,
  output int                                readings_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import mmc_pkg::*;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
    logic [PH_W-1:0]         phase;
  } reading_t;

  reading_t expected_readings[$];

  // register copies
  logic [ZB_W-1:0] z_bias;
  logic [CL_W-1:0] track_limit;

  // calibration state
  logic [$clog2(AVG_ROWS+1)-1:0] rows_in_avg;
  logic [15:0]                   axis_total  [3];
  logic [PH_W-1:0]               cal_phase;
  logic [CL_W-1:0]               tracked;
  logic signed [SPAN_W-1:0]      axis_hi     [3];
  logic signed [SPAN_W-1:0]      axis_lo     [3];
  logic signed [SPAN_W-1:0]      axis_center [3];
  logic signed [SCALE_W-1:0]     axis_gain   [3];

  function automatic int quotient_or_zero(int num, int den);
    return (den == 0) ? 0 : num / den;
  endfunction

  function automatic logic signed [OUT_W-1:0] clamp16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[OUT_W-1:0];
  endfunction

  function automatic void check_field(string field, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic track_and_correct(input logic req, input logic [RAW_W-1:0] rx,
                                   input logic [RAW_W-1:0] ry,
                                   input logic [RAW_W-1:0] rz);
    int avg [3];
    int z_span;
    logic [RAW_W-1:0] raw [3];
    reading_t r;
    raw[0] = rx;
    raw[1] = ry;
    raw[2] = rz;
    if (req == REQ_BUTTON) begin
      if (cal_phase != PH_Z) begin
        cal_phase = cal_phase + 1'b1;
        tracked = '0;
      end else begin
        // end of Z tracking: midpoints and scales from the running extremes
        z_span = int'(axis_hi[2]) - int'(axis_lo[2]);
        for (int k = 0; k < 3; k++)
          axis_center[k] = SPAN_W'((int'(axis_hi[k]) + int'(axis_lo[k])) / 2);
        axis_gain[0] = SCALE_W'(quotient_or_zero(z_span,
                                                 int'(axis_hi[0]) - int'(axis_lo[0])));
        axis_gain[1] = SCALE_W'(quotient_or_zero(z_span,
                                                 int'(axis_hi[1]) - int'(axis_lo[1])));
        axis_gain[2] = SCALE_W'(1);
        cal_phase = PH_NORMAL;
        tracked = '0;
      end
      return;
    end

    for (int k = 0; k < 3; k++)
      axis_total[k] += raw[k];
    rows_in_avg++;
    if (rows_in_avg != AVG_ROWS)
      return;

    for (int k = 0; k < 3; k++) begin
      avg[k] = int'(axis_total[k]) / AVG_ROWS;
      axis_total[k] = '0;
    end
    avg[2] += int'(z_bias);
    rows_in_avg = '0;

    if (cal_phase != PH_NORMAL && tracked < track_limit) begin
      for (int k = 0; k < 3; k++) begin
        // X/Y in the first tracking phase, Z in the second
        if ((cal_phase == PH_XY) == (k != 2)) begin
          if (avg[k] > axis_hi[k]) axis_hi[k] = SPAN_W'(avg[k]);
          if (avg[k] < axis_lo[k]) axis_lo[k] = SPAN_W'(avg[k]);
        end
      end
      tracked++;
    end

    r.x = clamp16(int'(axis_gain[0]) * (avg[0] - int'(axis_center[0])));
    r.y = clamp16(int'(axis_gain[1]) * (avg[1] - int'(axis_center[1])));
    r.z = clamp16(int'(axis_gain[2]) * (avg[2] - int'(axis_center[2])));
    r.phase = cal_phase;
    expected_readings.push_back(r);
  endtask

  always @(posedge clk) begin : watch
    reading_t oldest;
    if (!rst_n) begin
      expected_readings.delete();
      mismatch_count = 0;
      z_bias = Z_BIAS_RESET;
      track_limit = CAL_LENGTH_RESET;
      rows_in_avg = '0;
      cal_phase = PH_NORMAL;
      tracked = '0;
      for (int k = 0; k < 3; k++) begin
        axis_total[k] = '0;
        axis_hi[k] = '0;
        axis_lo[k] = SPAN_W'(MIN_RESET);
        axis_center[k] = '0;
        axis_gain[k] = '0;
      end
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ZB_ADDR: z_bias = pwdata[ZB_W-1:0];
          CL_ADDR: track_limit = pwdata[CL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          $error("out_valid: result with no expected reading waiting");
          mismatch_count++;
        end else begin
          oldest = expected_readings.pop_front();
          check_field("out_x", 32'(oldest.x), 32'(out_x));
          check_field("out_y", 32'(oldest.y), 32'(out_y));
          check_field("out_z", 32'(oldest.z), 32'(out_z));
          check_field("out_cal_phase", 32'(oldest.phase), 32'(out_cal_phase));
        end
      end
      if (in_valid && !in_stall)
        track_and_correct(in_req_type, in_raw_x, in_raw_y, in_raw_z);
    end
    readings_due = expected_readings.size();
  end

endmodule

[verif/magnetometer_minmax_calibration_tb.sv]
// ----------------------------------------------------------------------------
// magnetometer_minmax_calibration_tb
// Stimulus and verdict for the magnetometer min/max calibrator.
// ----------------------------------------------------------------------------
// Drives sample rows and button presses into the calibrator, reprograms z_bias
// and cal_length between calibration phases, and stalls the result side at
// random and once for a long stretch. A checker beside the block predicts
// every corrected reading; this module only reports the final verdict.
// ----------------------------------------------------------------------------
module magnetometer_minmax_calibration_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mmc_pkg::*;

  localparam int         CLK_PERIOD    = 10;
  localparam int         RESET_CYCLES  = 5;
  localparam int         AVG_ROWS      = 10;
  localparam int         ITEM_TARGET   = 700;
  localparam int         IDLE_PCT      = 22;
  localparam int         HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int         PRESSURE_ROWS = 12 * AVG_ROWS;  // rows offered into it
  localparam int         STEADY_FROM   = 350;   // window with no idling at all
  localparam int         STEADY_TO     = 500;
  localparam int         DRAIN_CYCLES  = 48;    // divider plus result pipeline
  localparam int         TIMEOUT_NS    = 2_000_000;
  localparam int         RAW_MAX       = (1 << RAW_W) - 1;
  localparam int         ZB_MAX        = (1 << ZB_W) - 1;
  localparam int         CL_MAX        = (1 << CL_W) - 1;
  localparam logic [2:0] ADDR_Z_BIAS     = 3'd0;
  localparam logic [2:0] ADDR_CAL_LENGTH = 3'd4;

  logic                    clk         = 1'b0;
  logic                    rst_n       = 1'b0;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic                    in_req_type = REQ_SAMPLE;
  logic [RAW_W-1:0]        in_raw_x    = '0;
  logic [RAW_W-1:0]        in_raw_y    = '0;
  logic [RAW_W-1:0]        in_raw_z    = '0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic signed [OUT_W-1:0] out_x;
  logic signed [OUT_W-1:0] out_y;
  logic signed [OUT_W-1:0] out_z;
  logic [PH_W-1:0]         out_cal_phase;
  logic                    psel        = 1'b0;
  logic                    penable     = 1'b0;
  logic                    pwrite      = 1'b0;
  logic [2:0]              paddr       = '0;
  logic [31:0]             pwdata      = '0;
  logic [31:0]             prdata;
  logic                    pready;

  int               mismatch_count;
  int               readings_due;
  int               items_sent     = 0;
  bit               steady         = 1'b0;
  bit               pressure_armed = 1'b0;
  logic [PH_W-1:0]  gen_phase      = PH_NORMAL;  // phase as the sender sees it
  logic [RAW_W-1:0] narrow_x;
  logic [RAW_W-1:0] narrow_y;

  always #(CLK_PERIOD / 2) clk = ~clk;

  magnetometer_minmax_calibration #(.AVG_ROWS(AVG_ROWS)) dut (.*);

  magnetometer_minmax_calibration_checker #(
    .AVG_ROWS(AVG_ROWS),
    .ZB_ADDR (ADDR_Z_BIAS),
    .CL_ADDR (ADDR_CAL_LENGTH)
  ) u_checker (.*);

  function automatic logic [RAW_W-1:0] rand_raw();
    return RAW_W'($urandom_range(0, RAW_MAX));
  endfunction

  // Pick a bias: the two extremes half of the time, anything in range otherwise.
  function automatic logic [31:0] pick_bias();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return ZB_MAX;
      default: return $urandom_range(0, ZB_MAX);
    endcase
  endfunction

  // Offer one transaction and hold it until accepted. Idle cycles go in
  // front of it at random, except inside the steady window.
  task automatic send_item(input logic req, input logic [RAW_W-1:0] x,
                           input logic [RAW_W-1:0] y, input logic [RAW_W-1:0] z);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_raw_x    <= x;
    in_raw_y    <= y;
    in_raw_z    <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (req == REQ_BUTTON)
      gen_phase = (gen_phase == PH_Z) ? PH_NORMAL : gen_phase + 1'b1;
    steady = (items_sent >= STEADY_FROM && items_sent < STEADY_TO);
  endtask

  task automatic press_button();
    send_item(REQ_BUTTON, rand_raw(), rand_raw(), rand_raw());
  endtask

  // Send one full average worth of rows. In narrow mode X stays fixed, Y
  // moves by one count and Z swings rail to rail from one average to the
  // next: that leaves a zero X span and a unit Y span against a wide Z span.
  task automatic send_average(input bit narrow, input int idx);
    logic [RAW_W-1:0] x, y, z;
    for (int r = 0; r < AVG_ROWS; r++) begin
      if (narrow) begin
        x = narrow_x;
        y = narrow_y + idx[0];
        z = idx[0] ? RAW_MAX[RAW_W-1:0] : '0;
      end else begin
        x = rand_raw();
        y = rand_raw();
        z = rand_raw();
      end
      send_item(REQ_SAMPLE, x, y, z);
    end
  endtask

  // Drop valid, wait for every expected reading, then give the divider and
  // the result pipeline time to go quiet before touching a register.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (readings_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands when pready is seen high.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One well-formed calibration: X/Y tracking, Z tracking, then a few normal
  // averages with the new midpoints and scales.
  task automatic calibration_run(input bit narrow);
    int n;
    logic [31:0] limit;
    // close out any calibration left open by a noise burst
    while (gen_phase != PH_NORMAL) press_button();
    settle();
    write_reg(ADDR_Z_BIAS, pick_bias());
    if (narrow) begin
      limit = CL_MAX;
    end else begin
      case ($urandom_range(0, 2))
        0:       limit = 1;
        1:       limit = CL_MAX;
        default: limit = $urandom_range(2, 8);
      endcase
    end
    write_reg(ADDR_CAL_LENGTH, limit);

    press_button();
    n = $urandom_range(2, 6);
    for (int a = 0; a < n; a++) send_average(narrow, a);
    if ($urandom_range(0, 1)) begin
      settle();
      write_reg(ADDR_Z_BIAS, pick_bias());
    end
    press_button();
    n = $urandom_range(2, 6);
    for (int a = 0; a < n; a++) send_average(narrow, a);
    press_button();
    n = $urandom_range(1, 4);
    for (int a = 0; a < n; a++) send_average(1'b0, a);
  endtask

  // Random rows with stray button presses; breaks row alignment and phases.
  task automatic noise_burst();
    int n;
    n = $urandom_range(5, 30);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0)
        press_button();
      else
        send_item(REQ_SAMPLE, rand_raw(), rand_raw(), rand_raw());
    end
  endtask

  // Result side: random stalls, plus one long hold-off once the sender has
  // armed it, long enough for the event queue to fill and in_stall to rise.
  initial begin : result_sink
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_armed && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin : stimulus
    int run_index;
    run_index = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Full-scale rows with reset settings: scales are still zero, so the
    // first corrected reading must be all zero in the normal phase.
    repeat (AVG_ROWS)
      send_item(REQ_SAMPLE, RAW_W'(RAW_MAX), RAW_W'(RAW_MAX), RAW_W'(RAW_MAX));
    settle();
    write_reg(ADDR_Z_BIAS, ZB_MAX);
    write_reg(ADDR_CAL_LENGTH, CL_MAX);
    // Step through all phases with nothing tracked: midpoints and scales
    // come from the untouched reset extremes.
    repeat (3) press_button();
    repeat (AVG_ROWS) send_item(REQ_SAMPLE, '0, '0, '0);

    // Hold off the receiver and keep offering rows in the normal phase:
    // the back end, the event queue and the front stages fill up and the
    // input stalls. Extremes stay untouched outside the tracking phases.
    pressure_armed = 1'b1;
    repeat (PRESSURE_ROWS) send_item(REQ_SAMPLE, rand_raw(), rand_raw(), rand_raw());

    // The first calibration is narrow so the spans start tight: zero X
    // divisor and a large Y scale that saturates the corrected Y readings.
    narrow_x = RAW_W'($urandom_range(100, 3000));
    narrow_y = RAW_W'($urandom_range(100, 3000));
    while (items_sent < ITEM_TARGET) begin
      if (run_index == 0 || $urandom_range(0, 99) < 70) begin
        calibration_run(run_index == 0);
        run_index++;
      end else begin
        noise_burst();
      end
    end

    settle();
    if (mismatch_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
